@@ hw/rtl/iaid_pkg.sv @@
// Package for the indexed array with insert and delete.
// Holds request kinds, status codes, the sequencer state type and the result struct.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package iaid_pkg;

	localparam int DEPTH_DEFAULT = 256;
	localparam int DATA_W        = 32;
	localparam int POS_W         = 9;
	localparam int KIND_W        = 3;
	localparam int STATUS_W      = 2;
	localparam int COUNT_OUT_W   = 9;

	// Request kinds.
	localparam logic [KIND_W-1:0] REQ_APPEND = 3'd0;
	localparam logic [KIND_W-1:0] REQ_INSERT = 3'd1;
	localparam logic [KIND_W-1:0] REQ_DELETE = 3'd2;
	localparam logic [KIND_W-1:0] REQ_READ   = 3'd3;
	localparam logic [KIND_W-1:0] REQ_WRITE  = 3'd4;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_WAIT,
		S_INS_RD,
		S_INS_TAIL,
		S_INS_PUT,
		S_DEL_RD,
		S_DEL_TAIL,
		S_FIN
	} seq_state_t;

	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		logic signed [DATA_W-1:0] read_word;
		logic [COUNT_OUT_W-1:0] count_after;
	} res_t;

endpackage

`default_nettype wire

@@ hw/rtl/iaid_if.sv @@
// Handshake interfaces for the request and result channels.
// Depends on iaid_pkg for the field widths.
`default_nettype none

interface iaid_req_if;
	logic                                valid;
	logic                                ready;
	logic [iaid_pkg::KIND_W-1:0]         req_type;
	logic signed [iaid_pkg::POS_W-1:0]   position;
	logic signed [iaid_pkg::DATA_W-1:0]  data_word;

	modport source (output valid, output req_type, output position, output data_word,
		input ready);
	modport sink (input valid, input req_type, input position, input data_word,
		output ready);
endinterface

interface iaid_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic [iaid_pkg::STATUS_W-1:0]         status;
	logic signed [iaid_pkg::DATA_W-1:0]    read_word;
	logic [iaid_pkg::COUNT_OUT_W-1:0]      count_after;

	modport source (output valid, output status, output read_word, output count_after,
		input ready);
	modport sink (input valid, input status, input read_word, input count_after,
		output ready);
endinterface

`default_nettype wire

@@ hw/rtl/iaid_store.sv @@
// Entry store: one write port and one read port with registered read data.
// Depends on iaid_pkg for the word width.
`default_nettype none

module iaid_store #(
	parameter int DEPTH = iaid_pkg::DEPTH_DEFAULT
) (
	input  wire logic                              clk,
	input  wire logic                              rd_en,
	input  wire logic [$clog2(DEPTH)-1:0]          rd_addr,
	output      logic [iaid_pkg::DATA_W-1:0]       rd_data,
	input  wire logic                              wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]          wr_addr,
	input  wire logic [iaid_pkg::DATA_W-1:0]       wr_data
);

	logic [iaid_pkg::DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/iaid_ctrl.sv @@
// Sequencer: checks each request, then drives the store one access per cycle,
// moving entries up or down through the single read and write port.
// Depends on iaid_pkg.
`default_nettype none

module iaid_ctrl #(
	parameter int DEPTH = iaid_pkg::DEPTH_DEFAULT
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output      logic                              in_ready,
	input  wire logic [iaid_pkg::KIND_W-1:0]       req_type,
	input  wire logic signed [iaid_pkg::POS_W-1:0] position,
	input  wire logic signed [iaid_pkg::DATA_W-1:0] data_word,
	output      logic                              res_valid,
	input  wire logic                              res_take,
	output      iaid_pkg::res_t                    res,
	output      logic                              rd_en,
	output      logic [$clog2(DEPTH)-1:0]          rd_addr,
	input  wire logic [iaid_pkg::DATA_W-1:0]       rd_data,
	output      logic                              wr_en,
	output      logic [$clog2(DEPTH)-1:0]          wr_addr,
	output      logic [iaid_pkg::DATA_W-1:0]       wr_data
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	iaid_pkg::seq_state_t state_q, state_d;

	logic [CW-1:0]                   count_q;
	logic [AW-1:0]                   ptr_q;
	logic [AW-1:0]                   idx_q;
	logic [AW-1:0]                   wa_q;
	logic                            wpend_q;
	logic [iaid_pkg::DATA_W-1:0]     word_q;
	logic [iaid_pkg::STATUS_W-1:0]   status_q;
	logic [iaid_pkg::DATA_W-1:0]     rword_q;

	logic                            accept;
	logic                            pos_ok;
	logic                            full;
	logic                            del_last;
	logic [AW-1:0]                   idx_w;
	logic [iaid_pkg::STATUS_W-1:0]   status_w;
	logic                            ok_w;

	assign accept   = in_valid && (state_q == iaid_pkg::S_IDLE);
	assign pos_ok   = !position[iaid_pkg::POS_W-1]
		&& (32'(position[iaid_pkg::POS_W-2:0]) < 32'(count_q));
	assign full     = (count_q == CW'(DEPTH));
	assign del_last = (32'(position[iaid_pkg::POS_W-2:0]) + 32'd1 == 32'(count_q));
	assign idx_w    = AW'(position[iaid_pkg::POS_W-2:0]);
	assign ok_w     = (status_w == iaid_pkg::ST_DONE);

	// Index is checked before fullness on an insert.
	always_comb begin
		unique case (req_type)
			iaid_pkg::REQ_APPEND: status_w = full ? iaid_pkg::ST_FULL : iaid_pkg::ST_DONE;
			iaid_pkg::REQ_INSERT: status_w = !pos_ok ? iaid_pkg::ST_RANGE
				: (full ? iaid_pkg::ST_FULL : iaid_pkg::ST_DONE);
			iaid_pkg::REQ_DELETE,
			iaid_pkg::REQ_READ,
			iaid_pkg::REQ_WRITE:  status_w = pos_ok ? iaid_pkg::ST_DONE : iaid_pkg::ST_RANGE;
			default:              status_w = iaid_pkg::ST_RANGE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iaid_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = ptr_q;
		wr_en    = wpend_q;
		wr_addr  = wa_q;
		wr_data  = rd_data;
		unique case (state_q)
			iaid_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					if (!ok_w) begin
						state_d = iaid_pkg::S_FIN;
					end else begin
						unique case (req_type)
							iaid_pkg::REQ_APPEND: begin
								wr_en   = 1'b1;
								wr_addr = AW'(count_q);
								wr_data = data_word;
								state_d = iaid_pkg::S_FIN;
							end
							iaid_pkg::REQ_INSERT: state_d = iaid_pkg::S_INS_RD;
							iaid_pkg::REQ_DELETE: begin
								state_d = del_last ? iaid_pkg::S_DEL_TAIL : iaid_pkg::S_DEL_RD;
							end
							iaid_pkg::REQ_READ: begin
								rd_en   = 1'b1;
								rd_addr = idx_w;
								state_d = iaid_pkg::S_RD_WAIT;
							end
							iaid_pkg::REQ_WRITE: begin
								wr_en   = 1'b1;
								wr_addr = idx_w;
								wr_data = data_word;
								state_d = iaid_pkg::S_FIN;
							end
							default: state_d = iaid_pkg::S_FIN;
						endcase
					end
				end
			end
			iaid_pkg::S_RD_WAIT: state_d = iaid_pkg::S_FIN;
			iaid_pkg::S_INS_RD: begin
				rd_en = 1'b1;
				if (ptr_q == idx_q) begin
					state_d = iaid_pkg::S_INS_TAIL;
				end
			end
			iaid_pkg::S_INS_TAIL: state_d = iaid_pkg::S_INS_PUT;
			iaid_pkg::S_INS_PUT: begin
				wr_en   = 1'b1;
				wr_addr = idx_q;
				wr_data = word_q;
				state_d = iaid_pkg::S_FIN;
			end
			iaid_pkg::S_DEL_RD: begin
				rd_en = 1'b1;
				if (CW'(ptr_q) == count_q - CW'(1)) begin
					state_d = iaid_pkg::S_DEL_TAIL;
				end
			end
			iaid_pkg::S_DEL_TAIL: state_d = iaid_pkg::S_FIN;
			iaid_pkg::S_FIN: begin
				if (res_take) begin
					state_d = iaid_pkg::S_IDLE;
				end
			end
			default: state_d = iaid_pkg::S_IDLE;
		endcase
	end

	// Live count and the pending write of a shifted entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			wpend_q <= 1'b0;
		end else begin
			wpend_q <= (state_q == iaid_pkg::S_INS_RD) || (state_q == iaid_pkg::S_DEL_RD);
			if ((accept && ok_w && (req_type == iaid_pkg::REQ_APPEND))
					|| (state_q == iaid_pkg::S_INS_PUT)) begin
				count_q <= count_q + CW'(1);
			end else if (state_q == iaid_pkg::S_DEL_TAIL) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		wa_q <= (state_q == iaid_pkg::S_INS_RD) ? ptr_q + AW'(1) : ptr_q - AW'(1);
		if (accept) begin
			word_q   <= data_word;
			idx_q    <= idx_w;
			status_q <= status_w;
			rword_q  <= '0;
			if (req_type == iaid_pkg::REQ_INSERT) begin
				ptr_q <= AW'(count_q - CW'(1));
			end else begin
				ptr_q <= idx_w + AW'(1);
			end
		end else if (state_q == iaid_pkg::S_INS_RD) begin
			ptr_q <= ptr_q - AW'(1);
		end else if (state_q == iaid_pkg::S_DEL_RD) begin
			ptr_q <= ptr_q + AW'(1);
		end
		if (state_q == iaid_pkg::S_RD_WAIT) begin
			rword_q <= rd_data;
		end
	end

	assign res_valid       = (state_q == iaid_pkg::S_FIN);
	assign res.status      = status_q;
	assign res.read_word   = rword_q;
	assign res.count_after = iaid_pkg::COUNT_OUT_W'(count_q);

endmodule

`default_nettype wire

@@ hw/rtl/indexed_array_insert_delete.sv @@
// Append, write and rejected requests go from idle straight to the result; a read first waits
// for the registered store data; an insert or a delete first shifts the entries behind its index.
// Throughput: one item at a time; the next item is taken once the previous result has moved
// into the output register. The shift loop is bound by the single store read and write port.
// Reset (arst_n, asynchronous, active low) empties the array and the output register; the
// entry store itself is not cleared and needs no clearing pass.
`default_nettype none

module indexed_array_insert_delete #(
	parameter int DEPTH = iaid_pkg::DEPTH_DEFAULT
) (
	input wire logic  clk,
	input wire logic  arst_n,
	iaid_req_if.sink  req,
	iaid_rsp_if.source rsp
);

	localparam int AW = $clog2(DEPTH);

	logic                          res_valid;
	logic                          res_take;
	iaid_pkg::res_t                res;

	logic                          rd_en;
	logic [AW-1:0]                 rd_addr;
	logic [iaid_pkg::DATA_W-1:0]   rd_data;
	logic                          wr_en;
	logic [AW-1:0]                 wr_addr;
	logic [iaid_pkg::DATA_W-1:0]   wr_data;

	logic                          rsp_valid_q;
	iaid_pkg::res_t                rsp_q;

	// The sequencer checks every request and, for insert and delete, walks the
	// store one entry per cycle through its single read and write port.
	iaid_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.req_type  (req.req_type),
		.position  (req.position),
		.data_word (req.data_word),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	iaid_store #(
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// The output register takes a finished result whenever it is empty or is
	// being drained in the same cycle, so the sequencer is freed at once and
	// can accept the next item while this result waits for the sink.
	assign res_take = res_valid && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_q.status;
	assign rsp.read_word   = rsp_q.read_word;
	assign rsp.count_after = rsp_q.count_after;

endmodule

`default_nettype wire
